>>> rtl/core/ean13_pkg.sv
// ----------------------------------------------------------------------------
// ean13_pkg
// types, constants and symbol tables shared by the ean-13 encoder and checker
// ----------------------------------------------------------------------------
package ean13_pkg;

	localparam int CODE_LEN    = 13;
	localparam int CHUNK_BITS  = 48;
	localparam int NUM_MODULES = 95;
	localparam int CNT_SAT     = 14;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_CHAR  = 2'd1,
		ST_BAD_LEN   = 2'd2,
		ST_BAD_CHECK = 2'd3
	} status_t;

	// input transaction
	typedef struct packed {
		logic [7:0] char_byte;
		logic       final_char;
	} char_t;

	// output transaction
	typedef struct packed {
		status_t                 status;
		logic [CHUNK_BITS-1:0]   module_bits;
		logic                    chunk_index;
		logic                    last_result;
	} result_t;

	// l code, bit 6 is the first module
	function automatic logic [6:0] l_code(input logic [3:0] d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h0D;
			4'd1: p = 7'h19;
			4'd2: p = 7'h13;
			4'd3: p = 7'h3D;
			4'd4: p = 7'h23;
			4'd5: p = 7'h31;
			4'd6: p = 7'h2F;
			4'd7: p = 7'h3B;
			4'd8: p = 7'h37;
			4'd9: p = 7'h0B;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

	// g code, bit 6 is the first module
	function automatic logic [6:0] g_code(input logic [3:0] d);
		logic [6:0] p;
		case (d)
			4'd0: p = 7'h27;
			4'd1: p = 7'h33;
			4'd2: p = 7'h1B;
			4'd3: p = 7'h21;
			4'd4: p = 7'h1D;
			4'd5: p = 7'h39;
			4'd6: p = 7'h05;
			4'd7: p = 7'h11;
			4'd8: p = 7'h09;
			4'd9: p = 7'h17;
			default: p = 7'h00;
		endcase
		return p;
	endfunction

	// left-half parity by first digit, bit k set means left digit k is g coded
	function automatic logic [5:0] parity_mask(input logic [3:0] d);
		logic [5:0] p;
		case (d)
			4'd0: p = 6'h00;
			4'd1: p = 6'h34;
			4'd2: p = 6'h2C;
			4'd3: p = 6'h1C;
			4'd4: p = 6'h32;
			4'd5: p = 6'h26;
			4'd6: p = 6'h0E;
			4'd7: p = 6'h2A;
			4'd8: p = 6'h1A;
			4'd9: p = 6'h16;
			default: p = 6'h00;
		endcase
		return p;
	endfunction

	// flip a 7-module symbol so the first module lands on the lowest bit
	function automatic logic [6:0] rev7(input logic [6:0] p);
		logic [6:0] r;
		for (int i = 0; i < 7; i++) begin
			r[i] = p[6-i];
		end
		return r;
	endfunction

	// remainder by ten of an 8-bit sum, by staged conditional subtraction
	function automatic logic [3:0] mod10(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (r >= 8'd160) r = r - 8'd160;
		if (r >= 8'd80)  r = r - 8'd80;
		if (r >= 8'd40)  r = r - 8'd40;
		if (r >= 8'd20)  r = r - 8'd20;
		if (r >= 8'd10)  r = r - 8'd10;
		return r[3:0];
	endfunction

endpackage

>>> rtl/core/ean13_barcode_encoder.sv
// ----------------------------------------------------------------------------
// ean13_barcode_encoder
// collects ean-13 characters, validates the code and emits the 95-module pattern
// ----------------------------------------------------------------------------
// a final character passes from the input register to the result register, where its first
// result is offered; a valid code gives two results, the first chunk followed by the second
// chunk once the sink takes the first
// throughput: one character per cycle; a final character waits in the input
// register only while the two-entry result buffer still holds earlier results
// reset: arst_n clears counters, flags and valid bits; the digit store is not reset
module ean13_barcode_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_ready,
	input  ean13_pkg::char_t    char_data,
	output logic                res_valid,
	input  logic                res_ready,
	output ean13_pkg::result_t  res_data
);

	// input register
	logic              s1_vld_s1;
	ean13_pkg::char_t  char_s1;

	// code state
	logic [3:0] digit_q [ean13_pkg::CODE_LEN];
	logic [3:0] count_q;
	logic [7:0] sum_q;
	logic       bad_q;

	// result buffer: head result and the pending second chunk
	logic                out_vld_q;
	ean13_pkg::result_t  out_q;
	logic                pend_vld_q;
	ean13_pkg::result_t  pend_q;

	logic       out_free;
	logic       s1_adv;
	logic       load;
	logic       is_digit;
	logic [3:0] cur_digit;
	logic       in_code;
	logic [4:0] term;
	logic [7:0] sum_nxt;
	logic [3:0] count_nxt;
	logic       bad_nxt;
	ean13_pkg::status_t status;
	logic [3:0] dig [ean13_pkg::CODE_LEN];
	logic [5:0] par;
	logic [ean13_pkg::NUM_MODULES-1:0] vec;
	ean13_pkg::result_t res0;
	ean13_pkg::result_t res1;

	// handshake control
	assign out_free   = !out_vld_q || (res_ready && !pend_vld_q);
	assign s1_adv     = s1_vld_s1 && (!char_s1.final_char || out_free);
	assign load       = s1_adv && char_s1.final_char;
	assign char_ready = !s1_vld_s1 || s1_adv;
	assign res_valid  = out_vld_q;
	assign res_data   = out_q;

	// character decode and running sum
	always_comb begin
		is_digit  = (char_s1.char_byte >= 8'h30) && (char_s1.char_byte <= 8'h39);
		cur_digit = 4'(char_s1.char_byte - 8'h30);
		in_code   = count_q < 4'(ean13_pkg::CODE_LEN);
		term      = count_q[0] ? (5'(cur_digit) + {cur_digit, 1'b0}) : 5'(cur_digit);
		sum_nxt   = sum_q;
		bad_nxt   = bad_q;
		if (in_code) begin
			if (is_digit) begin
				sum_nxt = sum_q + 8'(term);
			end else begin
				bad_nxt = 1'b1;
			end
		end
		count_nxt = (count_q < 4'(ean13_pkg::CNT_SAT)) ? count_q + 4'd1 : count_q;
	end

	// status with error priority
	always_comb begin
		if (bad_nxt) begin
			status = ean13_pkg::ST_BAD_CHAR;
		end else if (count_nxt != 4'(ean13_pkg::CODE_LEN)) begin
			status = ean13_pkg::ST_BAD_LEN;
		end else if (ean13_pkg::mod10(sum_nxt) != 4'd0) begin
			status = ean13_pkg::ST_BAD_CHECK;
		end else begin
			status = ean13_pkg::ST_OK;
		end
	end

	// module pattern; the thirteenth digit comes straight from the input register
	always_comb begin
		for (int i = 0; i < ean13_pkg::CODE_LEN - 1; i++) begin
			dig[i] = digit_q[i];
		end
		dig[ean13_pkg::CODE_LEN-1] = cur_digit;
		par = ean13_pkg::parity_mask(dig[0]);
		vec = '0;
		vec[2:0]   = 3'b101;
		vec[49:45] = 5'b01010;
		vec[94:92] = 3'b101;
		for (int k = 0; k < 6; k++) begin
			vec[3+7*k +: 7] = ean13_pkg::rev7(par[k] ? ean13_pkg::g_code(dig[1+k])
			                                         : ean13_pkg::l_code(dig[1+k]));
			vec[50+7*k +: 7] = ean13_pkg::rev7(~ean13_pkg::l_code(dig[7+k]));
		end
	end

	// result words
	always_comb begin
		res0.status      = status;
		res0.chunk_index = 1'b0;
		if (status == ean13_pkg::ST_OK) begin
			res0.module_bits = vec[ean13_pkg::CHUNK_BITS-1:0];
			res0.last_result = 1'b0;
		end else begin
			res0.module_bits = '0;
			res0.last_result = 1'b1;
		end
		res1.status      = ean13_pkg::ST_OK;
		res1.module_bits = {1'b0, vec[ean13_pkg::NUM_MODULES-1:ean13_pkg::CHUNK_BITS]};
		res1.chunk_index = 1'b1;
		res1.last_result = 1'b1;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_s1 <= 1'b0;
		end else if (char_ready) begin
			s1_vld_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			char_s1 <= char_data;
		end
	end

	// code state, cleared after every final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			bad_q   <= 1'b0;
		end else if (s1_adv) begin
			if (char_s1.final_char) begin
				count_q <= '0;
				sum_q   <= '0;
				bad_q   <= 1'b0;
			end else begin
				count_q <= count_nxt;
				sum_q   <= sum_nxt;
				bad_q   <= bad_nxt;
			end
		end
	end

	// digit store
	always_ff @(posedge clk) begin
		if (s1_adv && in_code && is_digit) begin
			digit_q[count_q] <= cur_digit;
		end
	end

	// result buffer valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q  <= 1'b1;
			pend_vld_q <= (status == ean13_pkg::ST_OK);
		end else if (out_vld_q && res_ready) begin
			out_vld_q  <= pend_vld_q;
			pend_vld_q <= 1'b0;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= res0;
			pend_q <= res1;
		end else if (out_vld_q && res_ready && pend_vld_q) begin
			out_q <= pend_q;
		end
	end

endmodule

>>> rtl/core/ean13_checker.sv
// ----------------------------------------------------------------------------
// ean13_checker
// port-level checks on the result stream of the ean-13 encoder
// ----------------------------------------------------------------------------
module ean13_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input ean13_pkg::result_t  res_data
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// first chunk is followed at once by the second chunk
	a_chunk_pair: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_data.last_result |=>
		res_valid && res_data.chunk_index && res_data.status == ean13_pkg::ST_OK)
		else $error("second chunk missing after first chunk");

	// error result shape
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ean13_pkg::ST_OK |->
		res_data.module_bits == '0 && !res_data.chunk_index && res_data.last_result)
		else $error("malformed error result");

	// second chunk shape, end guard ends on a bar
	a_hi_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.chunk_index |->
		res_data.last_result && !res_data.module_bits[47] && res_data.module_bits[46])
		else $error("malformed second chunk");

	// ok first chunk starts with the start guard
	a_lo_guard: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.chunk_index && res_data.status == ean13_pkg::ST_OK |->
		res_data.module_bits[2:0] == 3'b101 && !res_data.last_result)
		else $error("first chunk lacks start guard");

endmodule

bind ean13_barcode_encoder ean13_checker u_ean13_checker (.*);
